FILE: rtl/core/dbsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbsc_pkg
// Shared types and codes for the double-buffer swap controller.
// ----------------------------------------------------------------------------
package dbsc_pkg;

    localparam int ADDR_W  = 32;
    localparam int TMO_W   = 32;
    localparam int TOTAL_W = 32;
    localparam int CFG_IDX_W = 3;

    // event modes
    localparam logic [2:0] MODE_ACQUIRE   = 3'd0;
    localparam logic [2:0] MODE_DONE      = 3'd1;
    localparam logic [2:0] MODE_SUBMIT    = 3'd2;
    localparam logic [2:0] MODE_RESOLVE   = 3'd3;
    localparam logic [2:0] MODE_NET_READY = 3'd4;

    // producer ids
    localparam logic [1:0] PROD_NONE = 2'd0;
    localparam logic [1:0] PROD_NET  = 2'd1;

    // display outcome codes
    localparam logic [2:0] DISP_OK      = 3'd0;
    localparam logic [2:0] DISP_INVALID = 3'd1;
    localparam logic [2:0] DISP_BUSY    = 3'd2;
    localparam logic [2:0] DISP_TIMEOUT = 3'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BUF_A_BASE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUF_B_BASE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRONT_SEL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATH_READY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NET_ENABLE  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_PRODUCING = 3'd1,
        ST_READY     = 3'd2,
        ST_REQUESTED = 3'd3,
        ST_FAILED    = 3'd4
    } t_swap_state;

    typedef enum logic [3:0] {
        S_OK              = 4'd0,
        S_INVALID         = 4'd1,
        S_NOT_READY       = 4'd2,
        S_BUSY            = 4'd3,
        S_WRONG_OWNER     = 4'd4,
        S_BAD_FRAME       = 4'd5,
        S_TIMEOUT         = 4'd6,
        S_HW              = 4'd7,
        S_FRONT_UNCHANGED = 4'd8,
        S_FAILED_STATE    = 4'd9
    } t_status;

    typedef struct packed {
        logic [ADDR_W-1:0] buf_a_base;
        logic [ADDR_W-1:0] buf_b_base;
        logic              path_ready;
        logic              net_enable;
        logic              front_load;
        logic              front_value;
    } t_cfg;

    typedef struct packed {
        logic [2:0]        mode;
        logic [1:0]        producer_id;
        logic              frame_good;
        logic [ADDR_W-1:0] written_base;
        logic [TMO_W-1:0]  wait_limit;
        logic [2:0]        queue_status;
        logic [2:0]        wait_status;
        logic [ADDR_W-1:0] readback_addr;
    } t_item;

    typedef struct packed {
        t_status            status;
        logic [ADDR_W-1:0]  granted_back;
        logic [ADDR_W-1:0]  swap_target;
        logic [ADDR_W-1:0]  front_base;
        t_swap_state        state_code;
        t_status            error_seen;
        logic [TOTAL_W-1:0] swap_total;
        logic [TOTAL_W-1:0] drop_total;
    } t_result;

endpackage
`default_nettype wire

FILE: rtl/core/dbsc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbsc_in_if
// Event channel into the swap controller: valid/ready plus event fields.
// ----------------------------------------------------------------------------
interface dbsc_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [1:0]  producer_id;
    logic        frame_good;
    logic [31:0] written_base;
    logic [31:0] wait_limit;
    logic [2:0]  queue_status;
    logic [2:0]  wait_status;
    logic [31:0] readback_addr;

    modport source (
        output valid, mode, producer_id, frame_good, written_base,
               wait_limit, queue_status, wait_status, readback_addr,
        input  ready
    );
    modport sink (
        input  valid, mode, producer_id, frame_good, written_base,
               wait_limit, queue_status, wait_status, readback_addr,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/core/dbsc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbsc_out_if
// Result channel out of the swap controller: valid/ready plus result fields.
// ----------------------------------------------------------------------------
interface dbsc_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [31:0] granted_back;
    logic [31:0] swap_target;
    logic [31:0] front_base;
    logic [2:0]  state_code;
    logic [3:0]  error_seen;
    logic [31:0] swap_total;
    logic [31:0] drop_total;

    modport source (
        output valid, status, granted_back, swap_target, front_base,
               state_code, error_seen, swap_total, drop_total,
        input  ready
    );
    modport sink (
        input  valid, status, granted_back, swap_target, front_base,
               state_code, error_seen, swap_total, drop_total,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/core/dbsc_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbsc_cfg
// Configuration register file: buffer bases, front select and path enables.
// ----------------------------------------------------------------------------
module dbsc_cfg
    import dbsc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [31:0]          i_cfg_data,
    output t_cfg                      o_cfg
);

    logic [ADDR_W-1:0] r_buf_a_base;
    logic [ADDR_W-1:0] r_buf_b_base;
    logic              r_path_ready;
    logic              r_net_enable;

    // write one register per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_a_base <= '0;
            r_buf_b_base <= '0;
            r_path_ready <= 1'b1;
            r_net_enable <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BUF_A_BASE: r_buf_a_base <= i_cfg_data;
                REG_BUF_B_BASE: r_buf_b_base <= i_cfg_data;
                REG_PATH_READY: r_path_ready <= i_cfg_data[0];
                REG_NET_ENABLE: r_net_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // front select goes straight into the core's front flag
    always_comb begin
        o_cfg.buf_a_base  = r_buf_a_base;
        o_cfg.buf_b_base  = r_buf_b_base;
        o_cfg.path_ready  = r_path_ready;
        o_cfg.net_enable  = r_net_enable;
        o_cfg.front_load  = i_cfg_we && (i_cfg_idx == REG_FRONT_SEL);
        o_cfg.front_value = i_cfg_data[0];
    end

endmodule
`default_nettype wire

FILE: rtl/core/dbsc_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbsc_core
// Swap state machine: ownership checks, swap confirmation and counters.
// ----------------------------------------------------------------------------
module dbsc_core
    import dbsc_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire t_item i_item,
    input  wire logic  i_adv,
    output t_result    o_result
);

    t_swap_state            r_state, n_state;
    logic [1:0]             r_owner, n_owner;
    logic                   r_front_is_b, n_front_is_b;
    logic                   r_back_held, n_back_held;
    logic                   r_pending_held, n_pending_held;
    t_status                r_error, n_error;
    logic [COUNT_WIDTH-1:0] r_swap_cnt, n_swap_cnt;
    logic [COUNT_WIDTH-1:0] r_drop_cnt, n_drop_cnt;

    t_status           st;
    logic [ADDR_W-1:0] granted;
    logic [ADDR_W-1:0] target;
    logic [ADDR_W-1:0] back_addr;

    function automatic t_status map_display(input logic [2:0] code);
        t_status s;
        unique case (code)
            DISP_OK:      s = S_OK;
            DISP_INVALID: s = S_INVALID;
            DISP_BUSY:    s = S_BUSY;
            DISP_TIMEOUT: s = S_TIMEOUT;
            default:      s = S_HW;
        endcase
        return s;
    endfunction

    // hold state; load front select on a config write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_owner        <= PROD_NONE;
            r_front_is_b   <= 1'b0;
            r_back_held    <= 1'b0;
            r_pending_held <= 1'b0;
            r_error        <= S_OK;
            r_swap_cnt     <= '0;
            r_drop_cnt     <= '0;
        end else if (i_cfg.front_load) begin
            r_front_is_b <= i_cfg.front_value;
        end else if (i_adv) begin
            r_state        <= n_state;
            r_owner        <= n_owner;
            r_front_is_b   <= n_front_is_b;
            r_back_held    <= n_back_held;
            r_pending_held <= n_pending_held;
            r_error        <= n_error;
            r_swap_cnt     <= n_swap_cnt;
            r_drop_cnt     <= n_drop_cnt;
        end
    end

    assign back_addr = r_front_is_b ? i_cfg.buf_a_base : i_cfg.buf_b_base;

    // decide one event
    always_comb begin
        n_state        = r_state;
        n_owner        = r_owner;
        n_front_is_b   = r_front_is_b;
        n_back_held    = r_back_held;
        n_pending_held = r_pending_held;
        n_error        = r_error;
        n_swap_cnt     = r_swap_cnt;
        n_drop_cnt     = r_drop_cnt;
        st             = S_OK;
        granted        = '0;
        target         = '0;

        unique case (i_item.mode)
            MODE_ACQUIRE: begin
                if (i_item.producer_id == PROD_NONE) begin
                    st = S_INVALID;
                end else if (r_state == ST_FAILED) begin
                    st = S_FAILED_STATE;
                end else if (r_state != ST_IDLE) begin
                    st = S_BUSY;
                end else begin
                    n_back_held = 1'b1;
                    n_owner     = i_item.producer_id;
                    n_state     = ST_PRODUCING;
                    granted     = back_addr;
                end
            end
            MODE_DONE: begin
                if (r_state == ST_FAILED) begin
                    st = S_FAILED_STATE;
                end else if (r_state != ST_PRODUCING) begin
                    st = S_BUSY;
                end else if (i_item.producer_id != r_owner) begin
                    st = S_WRONG_OWNER;
                end else if (!i_item.frame_good) begin
                    n_drop_cnt     = r_drop_cnt + COUNT_WIDTH'(1);
                    n_back_held    = 1'b0;
                    n_pending_held = 1'b0;
                    n_owner        = PROD_NONE;
                    n_state        = ST_IDLE;
                    st             = S_BAD_FRAME;
                end else begin
                    n_state = ST_READY;
                end
            end
            MODE_SUBMIT: begin
                if (r_state == ST_FAILED) begin
                    st = S_FAILED_STATE;
                end else if (r_state == ST_REQUESTED) begin
                    st = S_BUSY;
                end else if (r_state != ST_READY) begin
                    st = S_NOT_READY;
                end else if (i_item.wait_limit == '0) begin
                    st = S_INVALID;
                end else if (!i_cfg.path_ready) begin
                    st = S_NOT_READY;
                end else begin
                    target = back_addr;
                    if (i_item.queue_status != DISP_OK ||
                        i_item.wait_status != DISP_OK ||
                        i_item.readback_addr != back_addr) begin
                        // park in failed with the pending buffer kept
                        if (i_item.queue_status != DISP_OK) begin
                            st = map_display(i_item.queue_status);
                        end else if (i_item.wait_status != DISP_OK) begin
                            st = map_display(i_item.wait_status);
                        end else begin
                            st = S_FRONT_UNCHANGED;
                        end
                        n_pending_held = r_back_held;
                        n_state        = ST_FAILED;
                        n_error        = st;
                        n_drop_cnt     = r_drop_cnt + COUNT_WIDTH'(1);
                    end else begin
                        n_front_is_b   = !r_front_is_b;
                        n_back_held    = 1'b0;
                        n_pending_held = 1'b0;
                        n_owner        = PROD_NONE;
                        n_state        = ST_IDLE;
                        n_swap_cnt     = r_swap_cnt + COUNT_WIDTH'(1);
                    end
                end
            end
            MODE_RESOLVE: begin
                if (r_state != ST_FAILED) begin
                    st = S_NOT_READY;
                end else begin
                    n_back_held    = 1'b0;
                    n_pending_held = 1'b0;
                    n_owner        = PROD_NONE;
                    n_state        = ST_IDLE;
                    if (r_pending_held && i_item.readback_addr == back_addr) begin
                        n_front_is_b = !r_front_is_b;
                        n_swap_cnt   = r_swap_cnt + COUNT_WIDTH'(1);
                        n_error      = S_OK;
                    end else begin
                        n_error = S_FRONT_UNCHANGED;
                        st      = S_FRONT_UNCHANGED;
                    end
                end
            end
            MODE_NET_READY: begin
                if (!i_cfg.net_enable) begin
                    st = S_NOT_READY;
                end else if (r_state == ST_FAILED) begin
                    st = S_FAILED_STATE;
                end else if (r_state != ST_PRODUCING || r_owner != PROD_NET) begin
                    st = S_WRONG_OWNER;
                end else if (i_item.written_base != back_addr ||
                             !i_item.frame_good) begin
                    // wrong buffer or bad frame: drop and release
                    n_drop_cnt     = r_drop_cnt + COUNT_WIDTH'(1);
                    n_back_held    = 1'b0;
                    n_pending_held = 1'b0;
                    n_owner        = PROD_NONE;
                    n_state        = ST_IDLE;
                    st = (i_item.written_base != back_addr) ? S_WRONG_OWNER
                                                            : S_BAD_FRAME;
                end else begin
                    n_state = ST_READY;
                end
            end
            default: begin
                st = S_INVALID;
            end
        endcase
    end

    // widen or trim counters to the result width
    logic [TOTAL_W-1:0] swap_total;
    logic [TOTAL_W-1:0] drop_total;

    generate
        if (COUNT_WIDTH >= TOTAL_W) begin : g_cnt_trim
            assign swap_total = n_swap_cnt[TOTAL_W-1:0];
            assign drop_total = n_drop_cnt[TOTAL_W-1:0];
        end else begin : g_cnt_pad
            assign swap_total = {{(TOTAL_W-COUNT_WIDTH){1'b0}}, n_swap_cnt};
            assign drop_total = {{(TOTAL_W-COUNT_WIDTH){1'b0}}, n_drop_cnt};
        end
    endgenerate

    // assemble the result seen after this event
    always_comb begin
        o_result.status       = st;
        o_result.granted_back = granted;
        o_result.swap_target  = target;
        o_result.front_base   = n_front_is_b ? i_cfg.buf_b_base : i_cfg.buf_a_base;
        o_result.state_code   = n_state;
        o_result.error_seen   = n_error;
        o_result.swap_total   = swap_total;
        o_result.drop_total   = drop_total;
    end

endmodule
`default_nettype wire

FILE: rtl/core/double_buffer_swap_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted item is loaded into the input register; its result moves on into the
// result register once that register is empty or being read.
// Throughput: one item per cycle; while a result waits unread, one more item
// is held in the input register and the input then stalls until it leaves.
// Reset: synchronous, active low; clears swap state and counters and returns
// the configuration registers to their defaults.
// ----------------------------------------------------------------------------
// double_buffer_swap_controller
// Two-framebuffer page-flip controller with ownership checks and counters.
// ----------------------------------------------------------------------------
module double_buffer_swap_controller
    import dbsc_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [31:0]          i_cfg_data,
    dbsc_in_if.sink                   i_in,
    dbsc_out_if.source                o_out
);

    t_cfg    cfg;
    t_item   r_item;
    logic    r_item_valid;
    t_result core_result;
    t_result r_result;
    logic    r_result_valid;
    logic    adv;
    logic    in_ready;

    dbsc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // move the held item into the result register when there is room
    assign adv      = r_item_valid && (!r_result_valid || o_out.ready);
    assign in_ready = !r_item_valid || adv;
    assign i_in.ready = in_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (in_ready) begin
            r_item_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_item.mode          <= i_in.mode;
            r_item.producer_id   <= i_in.producer_id;
            r_item.frame_good    <= i_in.frame_good;
            r_item.written_base  <= i_in.written_base;
            r_item.wait_limit    <= i_in.wait_limit;
            r_item.queue_status  <= i_in.queue_status;
            r_item.wait_status   <= i_in.wait_status;
            r_item.readback_addr <= i_in.readback_addr;
        end
    end

    dbsc_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_item   (r_item),
        .i_adv    (adv),
        .o_result (core_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else if (adv) begin
            r_result_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_result_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_result <= core_result;
        end
    end

    // drive the result channel
    assign o_out.valid        = r_result_valid;
    assign o_out.status       = r_result.status;
    assign o_out.granted_back = r_result.granted_back;
    assign o_out.swap_target  = r_result.swap_target;
    assign o_out.front_base   = r_result.front_base;
    assign o_out.state_code   = r_result.state_code;
    assign o_out.error_seen   = r_result.error_seen;
    assign o_out.swap_total   = r_result.swap_total;
    assign o_out.drop_total   = r_result.drop_total;

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for double_buffer_swap_controller. Drives swap events with random
// pacing on both channels, keeps its own copy of the swap state to predict the
// result of every accepted item, and checks each result field by field.
// ----------------------------------------------------------------------------
module tb;
    import dbsc_pkg::*;

    // display codes 4..7 all report a hardware fault
    localparam logic [2:0] DISP_HW_TOP = 3'd7;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [31:0]          cfg_data;

    dbsc_in_if  ev_ch ();
    dbsc_out_if res_ch ();

    double_buffer_swap_controller dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_in      (ev_ch),
        .o_out     (res_ch)
    );

    // predictor copy of configuration and swap state
    logic [31:0] cfg_base_a;
    logic [31:0] cfg_base_b;
    logic        cfg_path_ready;
    logic        cfg_net_en;
    t_swap_state flip_state;
    logic [1:0]  flip_owner;
    logic        front_is_b;
    logic        back_held;
    logic        pending_held;
    t_status     flip_error;
    logic [31:0] flip_count;
    logic [31:0] drop_count;

    t_result     flip_results_due[$];
    int          mismatch_count;
    bit          steady_pace;

    // generate clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // end a run that hangs
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [31:0] front_addr_now();
        return front_is_b ? cfg_base_b : cfg_base_a;
    endfunction

    function automatic logic [31:0] back_addr_now();
        return front_is_b ? cfg_base_a : cfg_base_b;
    endfunction

    function automatic t_status display_code_status(logic [2:0] code);
        case (code)
            DISP_OK:      return S_OK;
            DISP_INVALID: return S_INVALID;
            DISP_BUSY:    return S_BUSY;
            DISP_TIMEOUT: return S_TIMEOUT;
            default:      return S_HW;
        endcase
    endfunction

    function automatic void reset_model();
        cfg_base_a     = '0;
        cfg_base_b     = '0;
        cfg_path_ready = 1'b1;
        cfg_net_en     = 1'b0;
        front_is_b     = 1'b0;
        flip_state     = ST_IDLE;
        flip_owner     = PROD_NONE;
        back_held      = 1'b0;
        pending_held   = 1'b0;
        flip_error     = S_OK;
        flip_count     = '0;
        drop_count     = '0;
    endfunction

    function automatic void release_buffers();
        back_held    = 1'b0;
        pending_held = 1'b0;
        flip_owner   = PROD_NONE;
        flip_state   = ST_IDLE;
    endfunction

    function automatic void finish_swap();
        front_is_b = ~front_is_b;
        release_buffers();
        flip_count = flip_count + 32'd1;
    endfunction

    function automatic t_status abort_swap(t_status err);
        flip_state = ST_FAILED;
        flip_error = err;
        drop_count = drop_count + 32'd1;
        return err;
    endfunction

    function automatic t_status close_frame(logic good);
        if (!good) begin
            drop_count = drop_count + 32'd1;
            release_buffers();
            return S_BAD_FRAME;
        end
        flip_state = ST_READY;
        return S_OK;
    endfunction

    // advance the swap state by one event and return the result it causes
    function automatic t_result predict_flip(t_item ev);
        t_result     r;
        t_status     st;
        logic [31:0] granted;
        logic [31:0] target;
        st      = S_OK;
        granted = '0;
        target  = '0;
        case (ev.mode)
            MODE_ACQUIRE: begin
                if (ev.producer_id == PROD_NONE) st = S_INVALID;
                else if (flip_state == ST_FAILED) st = S_FAILED_STATE;
                else if (flip_state != ST_IDLE) st = S_BUSY;
                else begin
                    back_held  = 1'b1;
                    flip_owner = ev.producer_id;
                    flip_state = ST_PRODUCING;
                    granted    = back_addr_now();
                end
            end
            MODE_DONE: begin
                if (flip_state == ST_FAILED) st = S_FAILED_STATE;
                else if (flip_state != ST_PRODUCING) st = S_BUSY;
                else if (ev.producer_id != flip_owner) st = S_WRONG_OWNER;
                else st = close_frame(ev.frame_good);
            end
            MODE_SUBMIT: begin
                if (flip_state == ST_FAILED) st = S_FAILED_STATE;
                else if (flip_state == ST_REQUESTED) st = S_BUSY;
                else if (flip_state != ST_READY) st = S_NOT_READY;
                else if (ev.wait_limit == '0) st = S_INVALID;
                else if (!cfg_path_ready) st = S_NOT_READY;
                else begin
                    pending_held = back_held;
                    flip_state   = ST_REQUESTED;
                    target       = back_addr_now();
                    if (ev.queue_status != DISP_OK)
                        st = abort_swap(display_code_status(ev.queue_status));
                    else if (ev.wait_status != DISP_OK)
                        st = abort_swap(display_code_status(ev.wait_status));
                    else if (ev.readback_addr != target)
                        st = abort_swap(S_FRONT_UNCHANGED);
                    else
                        finish_swap();
                end
            end
            MODE_RESOLVE: begin
                if (flip_state != ST_FAILED) st = S_NOT_READY;
                else if (pending_held && ev.readback_addr == back_addr_now()) begin
                    finish_swap();
                    flip_error = S_OK;
                end else begin
                    release_buffers();
                    flip_error = S_FRONT_UNCHANGED;
                    st         = S_FRONT_UNCHANGED;
                end
            end
            MODE_NET_READY: begin
                if (!cfg_net_en) st = S_NOT_READY;
                else if (flip_state == ST_FAILED) st = S_FAILED_STATE;
                else if (flip_state != ST_PRODUCING || flip_owner != PROD_NET)
                    st = S_WRONG_OWNER;
                else if (ev.written_base != back_addr_now()) begin
                    drop_count = drop_count + 32'd1;
                    release_buffers();
                    st = S_WRONG_OWNER;
                end else st = close_frame(ev.frame_good);
            end
            default: st = S_INVALID;
        endcase
        r.status       = st;
        r.granted_back = granted;
        r.swap_target  = target;
        r.front_base   = front_addr_now();
        r.state_code   = flip_state;
        r.error_seen   = flip_error;
        r.swap_total   = flip_count;
        r.drop_total   = drop_count;
        return r;
    endfunction

    // pick the next random event, mostly following a legal swap sequence
    function automatic t_item next_flip_event();
        t_item ev;
        int    roll;
        ev.mode          = MODE_ACQUIRE;
        ev.producer_id   = 2'($urandom_range(0, 3));
        ev.frame_good    = ($urandom_range(0, 9) != 0);
        ev.written_base  = back_addr_now();
        ev.wait_limit    = $urandom;
        ev.queue_status  = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(1, 7)) : DISP_OK;
        ev.wait_status   = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(1, 7)) : DISP_OK;
        ev.readback_addr = ($urandom_range(0, 5) == 0) ? $urandom : back_addr_now();
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
            // noise: any mode with raw field values
            ev.mode          = 3'($urandom_range(0, 7));
            ev.written_base  = $urandom;
            ev.readback_addr = $urandom;
            ev.queue_status  = 3'($urandom_range(0, 7));
            ev.wait_status   = 3'($urandom_range(0, 7));
            ev.wait_limit    = ($urandom_range(0, 3) == 0) ? '0 : $urandom;
        end else begin
            case (flip_state)
                ST_IDLE: begin
                    ev.mode        = MODE_ACQUIRE;
                    ev.producer_id = 2'($urandom_range(1, 3));
                end
                ST_PRODUCING: begin
                    if (flip_owner == PROD_NET && cfg_net_en &&
                        ($urandom_range(0, 1) == 1)) begin
                        ev.mode = MODE_NET_READY;
                        if ($urandom_range(0, 9) == 0) ev.written_base = $urandom;
                    end else begin
                        ev.mode        = MODE_DONE;
                        ev.producer_id = ($urandom_range(0, 9) == 0) ?
                                         2'($urandom_range(0, 3)) : flip_owner;
                    end
                end
                ST_READY: ev.mode = MODE_SUBMIT;
                default:  ev.mode = MODE_RESOLVE;
            endcase
        end
        return ev;
    endfunction

    // send one item and record the result it should cause
    task automatic send_item(t_item ev);
        int gap;
        gap = steady_pace ? 0 : $urandom_range(0, 3);
        @(negedge i_clk);
        if (gap > 0) begin
            ev_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        ev_ch.mode          = ev.mode;
        ev_ch.producer_id   = ev.producer_id;
        ev_ch.frame_good    = ev.frame_good;
        ev_ch.written_base  = ev.written_base;
        ev_ch.wait_limit    = ev.wait_limit;
        ev_ch.queue_status  = ev.queue_status;
        ev_ch.wait_status   = ev.wait_status;
        ev_ch.readback_addr = ev.readback_addr;
        ev_ch.valid         = 1'b1;
        do begin
            @(posedge i_clk);
        end while (!ev_ch.ready);
        flip_results_due.push_back(predict_flip(ev));
    endtask

    task automatic send_ev(logic [2:0] mode, logic [1:0] who, logic good,
                           logic [31:0] rep, logic [31:0] tmo, logic [2:0] qst,
                           logic [2:0] wst, logic [31:0] rb);
        t_item ev;
        ev.mode          = mode;
        ev.producer_id   = who;
        ev.frame_good    = good;
        ev.written_base  = rep;
        ev.wait_limit    = tmo;
        ev.queue_status  = qst;
        ev.wait_status   = wst;
        ev.readback_addr = rb;
        send_item(ev);
    endtask

    // drop valid and hold until every outstanding result has drained
    task automatic wait_idle();
        @(negedge i_clk);
        ev_ch.valid = 1'b0;
        while (flip_results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge i_clk);
        cfg_we = 1'b0;
        case (idx)
            REG_BUF_A_BASE: cfg_base_a     = data;
            REG_BUF_B_BASE: cfg_base_b     = data;
            REG_FRONT_SEL:  front_is_b     = data[0];
            REG_PATH_READY: cfg_path_ready = data[0];
            REG_NET_ENABLE: cfg_net_en     = data[0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [31:0] base_a, logic [31:0] base_b,
                              logic front_b, logic path_ok, logic net_on);
        wait_idle();
        write_reg(REG_BUF_A_BASE, base_a);
        write_reg(REG_BUF_B_BASE, base_b);
        write_reg(REG_FRONT_SEL, {31'd0, front_b});
        write_reg(REG_PATH_READY, {31'd0, path_ok});
        write_reg(REG_NET_ENABLE, {31'd0, net_on});
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // check each accepted result against the oldest prediction
    initial begin : result_check
        int      stall;
        t_result got;
        t_result want;
        stall        = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                res_ch.ready = 1'b0;
                stall--;
            end else begin
                res_ch.ready = 1'b1;
            end
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready) begin
                got.status       = t_status'(res_ch.status);
                got.granted_back = res_ch.granted_back;
                got.swap_target  = res_ch.swap_target;
                got.front_base   = res_ch.front_base;
                got.state_code   = t_swap_state'(res_ch.state_code);
                got.error_seen   = t_status'(res_ch.error_seen);
                got.swap_total   = res_ch.swap_total;
                got.drop_total   = res_ch.drop_total;
                if (flip_results_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %p", $time, got);
                    mismatch_count++;
                end else begin
                    want = flip_results_due.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("granted_back", want.granted_back, got.granted_back);
                    check_field("swap_target", want.swap_target, got.swap_target);
                    check_field("front_base", want.front_base, got.front_base);
                    check_field("state_code", 32'(want.state_code),
                                32'(got.state_code));
                    check_field("error_seen", 32'(want.error_seen),
                                32'(got.error_seen));
                    check_field("swap_total", want.swap_total, got.swap_total);
                    check_field("drop_total", want.drop_total, got.drop_total);
                end
                stall = steady_pace ? 0 : $urandom_range(0, 3);
            end
        end
    end

    // reset configuration: network path off, unknown modes rejected
    task automatic test_reset_defaults();
        int m;
        send_ev(MODE_NET_READY, PROD_NET, 1'b1, '0, 32'd1, DISP_OK, DISP_OK, '0);
        send_ev(MODE_SUBMIT, PROD_NONE, 1'b1, '0, 32'd1, DISP_OK, DISP_OK, '0);
        for (m = MODE_NET_READY + 1; m < 8; m++)
            send_ev(3'(m), 2'($urandom_range(0, 3)), 1'b1, $urandom, $urandom,
                    DISP_OK, DISP_OK, $urandom);
    endtask

    // walk every mode through its accept and refuse paths
    task automatic test_flip_sequence();
        set_config(32'hFFFF_FFFF, 32'h0, 1'b0, 1'b1, 1'b1);
        send_ev(MODE_ACQUIRE, PROD_NONE, 1'b1, '0, 32'd1, DISP_OK, DISP_OK, '0);
        send_ev(MODE_DONE, 2'd2, 1'b1, '0, 32'd1, DISP_OK, DISP_OK, '0);
        send_ev(MODE_SUBMIT, 2'd2, 1'b1, '0, 32'd1, DISP_OK, DISP_OK, '0);
        send_ev(MODE_RESOLVE, 2'd2, 1'b1, '0, 32'd1, DISP_OK, DISP_OK, '0);
        send_ev(MODE_NET_READY, PROD_NET, 1'b1, '0, 32'd1, DISP_OK, DISP_OK, '0);
        // local producer: acquire, refuse a second owner, finish, swap
        send_ev(MODE_ACQUIRE, 2'd3, 1'b1, '0, 32'd1, DISP_OK, DISP_OK, '0);
        send_ev(MODE_ACQUIRE, 2'd2, 1'b1, '0, 32'd1, DISP_OK, DISP_OK, '0);
        send_ev(MODE_DONE, 2'd2, 1'b1, '0, 32'd1, DISP_OK, DISP_OK, '0);
        send_ev(MODE_DONE, 2'd3, 1'b1, '0, 32'd1, DISP_OK, DISP_OK, '0);
        send_ev(MODE_SUBMIT, 2'd3, 1'b1, '0, '0, DISP_OK, DISP_OK, '0);
        send_ev(MODE_SUBMIT, 2'd3, 1'b1, '0, 32'hFFFF_FFFF, DISP_OK, DISP_OK, 32'h0);
        // network producer: wrong address, then bad frame
        send_ev(MODE_ACQUIRE, PROD_NET, 1'b1, '0, 32'd1, DISP_OK, DISP_OK, '0);
        send_ev(MODE_NET_READY, PROD_NET, 1'b1, 32'h0, 32'd1, DISP_OK, DISP_OK, '0);
        send_ev(MODE_ACQUIRE, PROD_NET, 1'b1, '0, 32'd1, DISP_OK, DISP_OK, '0);
        send_ev(MODE_NET_READY, PROD_NET, 1'b0, 32'hFFFF_FFFF, 32'd1, DISP_OK, DISP_OK, '0);
        // hardware fault on queue, refused acquire, then resolved
        send_ev(MODE_ACQUIRE, 2'd2, 1'b1, '0, 32'd1, DISP_OK, DISP_OK, '0);
        send_ev(MODE_DONE, 2'd2, 1'b1, '0, 32'd1, DISP_OK, DISP_OK, '0);
        send_ev(MODE_SUBMIT, 2'd2, 1'b1, '0, 32'd5, DISP_HW_TOP, DISP_OK, '0);
        send_ev(MODE_ACQUIRE, 2'd2, 1'b1, '0, 32'd1, DISP_OK, DISP_OK, '0);
        send_ev(MODE_RESOLVE, 2'd2, 1'b1, '0, 32'd1, DISP_OK, DISP_OK, 32'hFFFF_FFFF);
        // wait timeout, unresolved readback
        send_ev(MODE_ACQUIRE, 2'd3, 1'b1, '0, 32'd1, DISP_OK, DISP_OK, '0);
        send_ev(MODE_DONE, 2'd3, 1'b1, '0, 32'd1, DISP_OK, DISP_OK, '0);
        send_ev(MODE_SUBMIT, 2'd3, 1'b1, '0, 32'd9, DISP_OK, DISP_TIMEOUT, 32'h0);
        send_ev(MODE_RESOLVE, 2'd3, 1'b1, '0, 32'd1, DISP_OK, DISP_OK, 32'h1234_5678);
        // network frame accepted, readback unchanged, then resolved
        send_ev(MODE_ACQUIRE, PROD_NET, 1'b1, '0, 32'd1, DISP_OK, DISP_OK, '0);
        send_ev(MODE_NET_READY, PROD_NET, 1'b1, 32'h0, 32'd1, DISP_OK, DISP_OK, '0);
        send_ev(MODE_SUBMIT, PROD_NET, 1'b1, '0, 32'd3, DISP_OK, DISP_OK, 32'hFFFF_FFFF);
        send_ev(MODE_RESOLVE, PROD_NET, 1'b1, '0, 32'd1, DISP_OK, DISP_OK, 32'h0);
    endtask

    // submit held off while the display path is down
    task automatic test_path_gate();
        set_config(32'h8000_0000, 32'h0000_0001, 1'b1, 1'b0, 1'b0);
        send_ev(MODE_ACQUIRE, 2'd2, 1'b1, '0, 32'd1, DISP_OK, DISP_OK, '0);
        send_ev(MODE_DONE, 2'd2, 1'b1, '0, 32'd1, DISP_OK, DISP_OK, '0);
        send_ev(MODE_SUBMIT, 2'd2, 1'b1, '0, 32'd7, DISP_OK, DISP_OK, 32'h8000_0000);
        set_config(32'h8000_0000, 32'h0000_0001, 1'b1, 1'b1, 1'b0);
        send_ev(MODE_SUBMIT, 2'd2, 1'b1, '0, 32'd7, DISP_OK, DISP_OK, 32'h8000_0000);
    endtask

    // random swap traffic over several configurations
    task automatic test_random_traffic();
        int          phase;
        int          n;
        logic [31:0] shared_base;
        for (phase = 0; phase < 6; phase++) begin
            shared_base = $urandom;
            case (phase)
                0: set_config(32'h0, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1);
                1: set_config(32'hFFFF_FFFF, 32'h0, 1'b1, 1'b1, 1'b0);
                2: set_config(shared_base, shared_base, 1'($urandom_range(0, 1)),
                              1'b1, 1'b1);
                3: set_config($urandom, $urandom, 1'b0, 1'b0, 1'b1);
                default: set_config($urandom, $urandom, 1'($urandom_range(0, 1)),
                                    1'b1, 1'b1);
            endcase
            for (n = 0; n < ((phase == 3) ? 30 : 90); n++) begin
                if (n % 20 == 0) steady_pace = ($urandom_range(0, 3) == 0);
                send_item(next_flip_event());
            end
        end
        steady_pace = 1'b0;
    endtask

    initial begin
        i_rst_n             = 1'b0;
        cfg_we              = 1'b0;
        cfg_idx             = '0;
        cfg_data            = '0;
        ev_ch.valid         = 1'b0;
        ev_ch.mode          = MODE_ACQUIRE;
        ev_ch.producer_id   = PROD_NONE;
        ev_ch.frame_good    = 1'b0;
        ev_ch.written_base  = '0;
        ev_ch.wait_limit    = '0;
        ev_ch.queue_status  = DISP_OK;
        ev_ch.wait_status   = DISP_OK;
        ev_ch.readback_addr = '0;
        steady_pace         = 1'b0;
        mismatch_count      = 0;
        reset_model();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_flip_sequence();
        test_path_gate();
        test_random_traffic();

        // drain, then allow for stray results
        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
